/* hw/rtl/pcd_pkg.sv */
// Shared types and constants of the prefix code stream decoder.
// Used by pcd_cell, pcd_table and prefix_code_stream_decoder; depends on nothing.
package pcd_pkg;

	localparam int MAX_CODE_LEN = 32;
	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
	localparam int SYM_W = 8;
	localparam int NSYM = 256;
	localparam int GRP = 16;
	localparam int NGRP = NSYM / GRP;

	localparam logic [7:0] SEP_CODE = 8'd189;
	localparam logic [7:0] SEP_ENTRY = 8'd190;
	localparam logic [7:0] SEP_HEADER = 8'd191;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_ONE = 8'h31;
	localparam logic [7:0] END_SYM_RST = 8'd129;

	localparam logic [1:0] KIND_SYM = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_OVF = 2'd2;

	typedef struct packed {
		logic en;
		logic [SYM_W-1:0] key;
		logic bad;
		logic bit_val;
	} wr_req_t;

	typedef struct packed {
		logic hit;
		logic [SYM_W-1:0] sym;
	} match_t;

endpackage

/* hw/rtl/pcd_cell.sv */
// One code table entry with its compare and its link in the lowest-symbol chain.
// Depends on pcd_pkg.
module pcd_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic clear,
	input  pcd_pkg::wr_req_t wr,
	input  logic [pcd_pkg::SYM_W-1:0] idx,
	input  logic [pcd_pkg::MAX_CODE_LEN-1:0] key_code,
	input  logic [pcd_pkg::LEN_W-1:0] key_len,
	input  logic hit_in,
	input  logic [pcd_pkg::SYM_W-1:0] sym_in,
	output logic hit_out,
	output logic [pcd_pkg::SYM_W-1:0] sym_out
);

	logic [pcd_pkg::LEN_W-1:0] len_q;
	logic [pcd_pkg::MAX_CODE_LEN-1:0] code_q;
	logic bad_q;
	logic sel;
	logic full;
	logic match;

	assign sel = wr.en && (wr.key == idx);
	assign full = (len_q >= pcd_pkg::LEN_W'(pcd_pkg::MAX_CODE_LEN));
	assign match = !bad_q && (len_q != '0) && (len_q == key_len) && (code_q == key_code);
	assign hit_out = hit_in || match;
	assign sym_out = hit_in ? sym_in : idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			bad_q <= 1'b0;
		end else if (clear) begin
			len_q <= '0;
			bad_q <= 1'b0;
		end else if (sel) begin
			if (wr.bad || full) begin
				bad_q <= 1'b1;
			end else begin
				len_q <= len_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && !wr.bad && !full) begin
			if (len_q == '0) begin
				code_q <= {{(pcd_pkg::MAX_CODE_LEN-1){1'b0}}, wr.bit_val};
			end else begin
				code_q <= {code_q[pcd_pkg::MAX_CODE_LEN-2:0], wr.bit_val};
			end
		end
	end

endmodule

/* hw/rtl/pcd_table.sv */
// Row of table cells in groups, with a registered group stage and a final
// lowest-symbol pick. Depends on pcd_pkg and pcd_cell.
module pcd_table (
	input  logic clk,
	input  logic arst_n,
	input  logic clear,
	input  pcd_pkg::wr_req_t wr,
	input  logic [pcd_pkg::MAX_CODE_LEN-1:0] key_code,
	input  logic [pcd_pkg::LEN_W-1:0] key_len,
	output pcd_pkg::match_t result
);

	logic [pcd_pkg::GRP:0] hc [pcd_pkg::NGRP];
	logic [pcd_pkg::SYM_W-1:0] sc [pcd_pkg::NGRP][pcd_pkg::GRP+1];
	logic grp_hit_s1 [pcd_pkg::NGRP];
	logic [pcd_pkg::SYM_W-1:0] grp_sym_s1 [pcd_pkg::NGRP];

	for (genvar g = 0; g < pcd_pkg::NGRP; g++) begin : g_grp
		assign hc[g][0] = 1'b0;
		assign sc[g][0] = '0;
		for (genvar c = 0; c < pcd_pkg::GRP; c++) begin : g_cell
			pcd_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.clear(clear),
				.wr(wr),
				.idx(pcd_pkg::SYM_W'(g * pcd_pkg::GRP + c)),
				.key_code(key_code),
				.key_len(key_len),
				.hit_in(hc[g][c]),
				.sym_in(sc[g][c]),
				.hit_out(hc[g][c+1]),
				.sym_out(sc[g][c+1])
			);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				grp_hit_s1[g] <= 1'b0;
			end else begin
				grp_hit_s1[g] <= hc[g][pcd_pkg::GRP];
			end
		end

		always_ff @(posedge clk) begin
			grp_sym_s1[g] <= sc[g][pcd_pkg::GRP];
		end
	end

	always_comb begin
		result.hit = 1'b0;
		result.sym = '0;
		for (int g = pcd_pkg::NGRP - 1; g >= 0; g--) begin
			if (grp_hit_s1[g]) begin
				result.hit = 1'b1;
				result.sym = grp_sym_s1[g];
			end
		end
	end

endmodule

/* hw/rtl/prefix_code_stream_decoder.sv */
// Top level of the prefix code stream decoder: header parse, bit engine, output stage.
// Depends on pcd_pkg and pcd_table.
//
//   channel | signals                                   | direction
//   input   | in_valid, in_stall, in_byte, stream_start | request in
//   output  | out_valid, out_stall, symbol, kind, last_of_run | request out
//   config  | cfg_we, cfg_wdata (end symbol)            | write only
//
// A header byte leaves in_stall low. A data byte is decoded bit by bit, each bit a
// compare in the cell row, then the group pick, and then the result is flushed;
// in_stall stays high until the flush ends, which comes sooner after the end symbol.
// arst_n clears the table, the phase and the end symbol (to 129).
// A stalled output holds the bit engine when a second result must leave, and holds the flush while a result is held.
module prefix_code_stream_decoder (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] in_byte,
	input  logic stream_start,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] symbol,
	output logic [1:0] kind,
	output logic last_of_run,
	input  logic cfg_we,
	input  logic [7:0] cfg_wdata
);

	typedef enum logic [1:0] {PH_KEY, PH_CODE, PH_DATA, PH_DONE} phase_t;
	typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_RES, ST_FLUSH} state_t;

	localparam int MAXL = pcd_pkg::MAX_CODE_LEN;

	state_t st_q;
	phase_t phase_q;
	phase_t ph_eff;
	logic [7:0] key_q;
	logic [7:0] end_sym_q;
	logic [MAXL-1:0] pend_code_q;
	logic [pcd_pkg::LEN_W-1:0] pend_len_q;
	logic [7:0] byte_q;
	logic [2:0] cnt_q;
	logic held_v_q;
	logic [7:0] held_sym_q;
	logic [1:0] held_kind_q;
	logic out_valid_q;
	logic [7:0] symbol_q;
	logic [1:0] kind_q;
	logic last_q;

	logic in_acc;
	logic slot_free;
	logic tbl_clear;
	pcd_pkg::wr_req_t wr;
	pcd_pkg::match_t mt;
	logic [MAXL-1:0] key_code;
	logic [pcd_pkg::LEN_W-1:0] key_len;
	logic res_v;
	logic [1:0] res_kind;
	logic [7:0] res_sym;

	assign in_stall = (st_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign ph_eff = stream_start ? PH_KEY : phase_q;
	assign tbl_clear = in_acc && stream_start;

	assign wr.en = in_acc && (ph_eff == PH_CODE) && (in_byte != pcd_pkg::SEP_ENTRY);
	assign wr.key = key_q;
	assign wr.bad = !((in_byte == pcd_pkg::CHAR_ZERO) || (in_byte == pcd_pkg::CHAR_ONE));
	assign wr.bit_val = (in_byte == pcd_pkg::CHAR_ONE);

	assign key_code = {pend_code_q[MAXL-2:0], byte_q[7]};
	assign key_len = pend_len_q + 1'b1;

	pcd_table u_table (
		.clk(clk),
		.arst_n(arst_n),
		.clear(tbl_clear),
		.wr(wr),
		.key_code(key_code),
		.key_len(key_len),
		.result(mt)
	);

	always_comb begin
		res_v = mt.hit || (key_len >= pcd_pkg::LEN_W'(MAXL));
		if (mt.hit) begin
			res_sym = mt.sym;
			res_kind = (mt.sym == end_sym_q) ? pcd_pkg::KIND_END : pcd_pkg::KIND_SYM;
		end else begin
			res_sym = '0;
			res_kind = pcd_pkg::KIND_OVF;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol = symbol_q;
	assign kind = kind_q;
	assign last_of_run = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			phase_q <= PH_KEY;
			key_q <= '0;
			end_sym_q <= pcd_pkg::END_SYM_RST;
			pend_code_q <= '0;
			pend_len_q <= '0;
			byte_q <= '0;
			cnt_q <= '0;
			held_v_q <= 1'b0;
			held_sym_q <= '0;
			held_kind_q <= '0;
			out_valid_q <= 1'b0;
			symbol_q <= '0;
			kind_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				end_sym_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (stream_start) begin
							pend_code_q <= '0;
							pend_len_q <= '0;
							phase_q <= PH_KEY;
							key_q <= in_byte;
						end
						case (ph_eff)
							PH_KEY: begin
								if (in_byte == pcd_pkg::SEP_HEADER) begin
									phase_q <= PH_DATA;
								end else if (in_byte == pcd_pkg::SEP_CODE) begin
									phase_q <= PH_CODE;
								end else begin
									key_q <= in_byte;
								end
							end
							PH_CODE: begin
								if (in_byte == pcd_pkg::SEP_ENTRY) begin
									phase_q <= PH_KEY;
									key_q <= in_byte;
								end
							end
							PH_DATA: begin
								byte_q <= in_byte;
								cnt_q <= '0;
								st_q <= ST_CMP;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CMP: begin
					st_q <= ST_RES;
				end
				ST_RES: begin
					if (!(res_v && held_v_q && !slot_free)) begin
						if (res_v) begin
							if (held_v_q) begin
								out_valid_q <= 1'b1;
								symbol_q <= held_sym_q;
								kind_q <= held_kind_q;
								last_q <= 1'b0;
							end
							held_v_q <= 1'b1;
							held_sym_q <= res_sym;
							held_kind_q <= res_kind;
							pend_code_q <= '0;
							pend_len_q <= '0;
						end else begin
							pend_code_q <= key_code;
							pend_len_q <= key_len;
						end
						byte_q <= {byte_q[6:0], 1'b0};
						cnt_q <= cnt_q + 1'b1;
						if (res_v && (res_kind == pcd_pkg::KIND_END)) begin
							phase_q <= PH_DONE;
							st_q <= ST_FLUSH;
						end else if (cnt_q == 3'd7) begin
							st_q <= ST_FLUSH;
						end else begin
							st_q <= ST_CMP;
						end
					end
				end
				ST_FLUSH: begin
					if (!held_v_q) begin
						st_q <= ST_IDLE;
					end else if (slot_free) begin
						out_valid_q <= 1'b1;
						symbol_q <= held_sym_q;
						kind_q <= held_kind_q;
						last_q <= 1'b1;
						held_v_q <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
